// ===== rtl/tsd_pkg.sv =====
package tsd_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CNT_W = $clog2(NUM_DIGITS + 1);

   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = 1;
   localparam int FQ_CNT_W = 2;

   localparam logic [1:0] CSR_RIGHT_JUSTIFY = 2'd0;
   localparam logic [1:0] CSR_PERIOD_AS_DIGIT = 2'd1;
   localparam logic [1:0] CSR_DIGITS_USED = 2'd2;

   localparam logic [7:0] SEG_BLANK = 8'b00000000;
   localparam logic [7:0] SEG_POINT = 8'b00000001;
   localparam logic [7:0] SEG_ALL = 8'b11111111;
   localparam logic [7:0] SEG_DASH = 8'b00000010;
   localparam logic [7:0] SEG_UNDERSCORE = 8'b00010000;
   localparam logic [7:0] SEG_EQUALS = 8'b00010010;
   localparam logic [7:0] SEG_QUOTE = 8'b01000100;

   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [7:0] DIGIT_GLYPHS [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4, 8'hFE, 8'hF6
   };

   localparam logic [7:0] LETTER_GLYPHS [26] = '{
      8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h6E,
      8'h60, 8'h78, 8'h6E, 8'h1C, 8'h2A, 8'h2A, 8'hFC, 8'hCE,
      8'hE6, 8'h0A, 8'hB6, 8'h1E, 8'h7C, 8'h7C, 8'h7C, 8'h6E,
      8'h76, 8'hDA
   };

   typedef struct packed {
      logic       right_justify;
      logic       period_as_digit;
      logic [2:0] digits_used;
   } cfg_type;

   typedef struct packed {
      logic [NUM_DIGITS-1:0][7:0] segs;
      logic                       overflow;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fq_status_type;

   function automatic logic [7:0] glyph_of(input logic [7:0] ch);
      logic [7:0] rel;
      logic [7:0] seg;
      rel = 8'd0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         rel = ch - CHAR_UPPER_A;
         seg = LETTER_GLYPHS[rel[4:0]];
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         rel = ch - CHAR_LOWER_A;
         seg = LETTER_GLYPHS[rel[4:0]];
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         rel = ch - CHAR_ZERO;
         seg = DIGIT_GLYPHS[rel[3:0]];
      end else begin
         unique case (ch)
            CHAR_SPACE:      seg = SEG_BLANK;
            CHAR_PERIOD:     seg = SEG_POINT;
            CHAR_DASH:       seg = SEG_DASH;
            CHAR_UNDERSCORE: seg = SEG_UNDERSCORE;
            CHAR_EQUALS:     seg = SEG_EQUALS;
            CHAR_QUOTE:      seg = SEG_QUOTE;
            default:         seg = SEG_ALL;
         endcase
      end
      return seg;
   endfunction

   function automatic logic [1:0] idx_to_port(input logic [DIGIT_IDX_W-1:0] idx);
      logic [DIGIT_IDX_W+1:0] wide;
      wide = {2'b00, idx};
      return wide[1:0];
   endfunction

endpackage

// ===== rtl/tsd_front.sv =====
module tsd_front (
   input  logic                clock,
   input  logic                reset,
   input  tsd_pkg::cfg_type    cfg,
   input  logic                req_accept,
   input  logic [7:0]          req_character,
   input  logic                req_end_of_text,
   output logic                push,
   output tsd_pkg::frame_type  push_frame
);
   import tsd_pkg::*;

   logic [NUM_DIGITS-1:0][7:0] store_ff, store_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       drop_ff, drop_in;
   logic [CNT_W-1:0]           cap;
   logic [CNT_W-1:0]           prev;
   logic [CNT_W-1:0]           offset;
   logic [CNT_W-1:0]           rel [NUM_DIGITS];
   logic                       merge;

   always_comb begin
      if (cfg.digits_used == 3'd0) begin
         cap = CNT_W'(1);
      end else if (int'(cfg.digits_used) > NUM_DIGITS) begin
         cap = CNT_W'(NUM_DIGITS);
      end else begin
         cap = CNT_W'(cfg.digits_used);
      end
   end

   assign prev = fill_ff - CNT_W'(1);
   assign merge = (req_character == CHAR_PERIOD) && !cfg.period_as_digit &&
                  (fill_ff != '0);

   always_comb begin
      store_in = store_ff;
      fill_in = fill_ff;
      drop_in = drop_ff;
      if (merge) begin
         store_in[prev[DIGIT_IDX_W-1:0]] = store_ff[prev[DIGIT_IDX_W-1:0]] | SEG_POINT;
      end else if (fill_ff < cap) begin
         store_in[fill_ff[DIGIT_IDX_W-1:0]] = glyph_of(req_character);
         fill_in = fill_ff + CNT_W'(1);
      end else begin
         drop_in = 1'b1;
      end
   end

   assign offset = cfg.right_justify ? (CNT_W'(NUM_DIGITS) - fill_in) : '0;

   always_comb begin
      for (int p = 0; p < NUM_DIGITS; p++) begin
         rel[p] = CNT_W'(p) - offset;
         if ((CNT_W'(p) >= offset) && (rel[p] < fill_in)) begin
            push_frame.segs[p] = store_in[rel[p][DIGIT_IDX_W-1:0]];
         end else begin
            push_frame.segs[p] = SEG_BLANK;
         end
      end
      push_frame.overflow = drop_in;
   end

   assign push = req_accept && req_end_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         drop_ff <= 1'b0;
      end else if (push) begin
         fill_ff <= '0;
         drop_ff <= 1'b0;
      end else if (req_accept) begin
         fill_ff <= fill_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         store_ff <= store_in;
      end
   end

endmodule

// ===== rtl/tsd_queue.sv =====
module tsd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tsd_pkg::frame_type    push_frame,
   input  logic                  pop,
   output tsd_pkg::frame_type    pop_frame,
   output tsd_pkg::fq_status_type status
);
   import tsd_pkg::*;

   frame_type             entry_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full = (count_ff == FQ_CNT_W'(FQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign pop_frame = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FQ_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + FQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== rtl/tsd_back.sv =====
module tsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tsd_pkg::frame_type     pop_frame,
   input  tsd_pkg::fq_status_type status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_digit_index,
   output logic [7:0]             rsp_segments,
   output logic                   rsp_overflow,
   output logic                   rsp_last_digit
);
   import tsd_pkg::*;

   frame_type              frame_ff;
   logic                   busy_ff, busy_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   is_last;
   logic                   done;

   assign is_last = (idx_ff == DIGIT_IDX_W'(NUM_DIGITS - 1));
   assign done = busy_ff && rsp_ready && is_last;
   assign pop = !status.empty && (!busy_ff || done);

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         idx_in = idx_ff + DIGIT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_ff <= pop_frame;
      end
   end

   assign rsp_valid = busy_ff;
   assign rsp_digit_index = idx_to_port(idx_ff);
   assign rsp_segments = frame_ff.segs[idx_ff];
   assign rsp_overflow = frame_ff.overflow;
   assign rsp_last_digit = is_last;

endmodule

// ===== rtl/text_to_seven_segment_display.sv =====
// Text to seven-segment decoder for a four digit display.
// Characters arrive one per request on the req_ channel; the request that
// carries end_of_text closes the frame. The block then returns four digit
// words on the rsp_ channel, leftmost digit first, the last one flagged by
// rsp_last_digit; rsp_overflow tells whether characters were dropped.
// A character request is taken in every cycle while the frame queue has
// room. A closed frame passes through the queue into the output frame register
// before its first word is offered; the following words come one per cycle
// while rsp_ready is high, and the next frame follows without a gap.
// The queue holds two finished frames; when the receiver stalls, the
// current word is held and req_ready drops once both entries are full.
// The user writes registers through csr_wen, csr_index and csr_wdata only
// while the block is idle; the block does not enforce this. Reset empties the
// frame and queue, sets right_justify and period_as_digit to 0, digits_used to 4.
module text_to_seven_segment_display (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_digit_index,
   output logic [7:0] rsp_segments,
   output logic       rsp_overflow,
   output logic       rsp_last_digit,
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_wdata
);
   import tsd_pkg::*;

   cfg_type       cfg_ff;
   frame_type     push_frame;
   frame_type     pop_frame;
   fq_status_type status;
   logic          req_accept;
   logic          push;
   logic          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_justify <= 1'b0;
         cfg_ff.period_as_digit <= 1'b0;
         cfg_ff.digits_used <= 3'(NUM_DIGITS);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_RIGHT_JUSTIFY:   cfg_ff.right_justify <= csr_wdata[0];
            CSR_PERIOD_AS_DIGIT: cfg_ff.period_as_digit <= csr_wdata[0];
            CSR_DIGITS_USED:     cfg_ff.digits_used <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !status.full;
   assign req_accept = req_valid && req_ready;

   tsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_accept      (req_accept),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_frame      (push_frame)
   );

   tsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (status)
   );

   tsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_frame       (pop_frame),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_index (rsp_digit_index),
      .rsp_segments    (rsp_segments),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_digit  (rsp_last_digit)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int DIGITS = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASES = 12;
   localparam int PHASE_CHARACTERS = 34;
   localparam int MAX_PRINTED = 100;

   localparam logic [7:0] POINT_BIT = 8'h01;
   localparam logic [7:0] ALL_LIT = 8'hFF;
   localparam logic [7:0] BLANK = 8'h00;
   localparam logic [7:0] PERIOD = 8'h2E;
   localparam logic [7:0] QUOTE = 8'h22;

   localparam logic [7:0] NUMERAL_SEGS [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4, 8'hFE, 8'hF6
   };
   localparam logic [7:0] LETTER_SEGS [26] = '{
      8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h6E,
      8'h60, 8'h78, 8'h6E, 8'h1C, 8'h2A, 8'h2A, 8'hFC, 8'hCE,
      8'hE6, 8'h0A, 8'hB6, 8'h1E, 8'h7C, 8'h7C, 8'h7C, 8'h6E,
      8'h76, 8'hDA
   };
   localparam logic [7:0] SYMBOL_CODES [5] = '{8'h20, 8'h2D, 8'h5F, 8'h3D, 8'h22};
   localparam logic [7:0] SYMBOL_SEGS [5] = '{8'h00, 8'h02, 8'h10, 8'h12, 8'h44};

   typedef struct packed {
      logic [1:0] position;
      logic [7:0] segments;
      logic       overflow;
      logic       last_digit;
   } digit_word_type;

   class digit_word_board_type;
      bit             right_justify;
      bit             period_as_digit;
      bit [2:0]       digits_used;
      logic [7:0]     stored [DIGITS];
      int             filled;
      bit             dropped;
      int             mismatches;
      digit_word_type expected_words [$];

      function new();
         right_justify = 1'b0;
         period_as_digit = 1'b0;
         digits_used = 3'd4;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (stored[k]) stored[k] = BLANK;
         filled = 0;
         dropped = 1'b0;
      endfunction

      function void set_register(logic [1:0] index, logic [2:0] value);
         case (index)
            tsd_pkg::CSR_RIGHT_JUSTIFY: right_justify = value[0];
            tsd_pkg::CSR_PERIOD_AS_DIGIT: period_as_digit = value[0];
            tsd_pkg::CSR_DIGITS_USED: digits_used = value;
            default: ;
         endcase
      endfunction

      function logic [7:0] segment_pattern(logic [7:0] code);
         logic [7:0] seg;
         seg = ALL_LIT;
         if (code >= "A" && code <= "Z") begin
            seg = LETTER_SEGS[code - "A"];
         end else if (code >= "a" && code <= "z") begin
            seg = LETTER_SEGS[code - "a"];
         end else if (code >= "0" && code <= "9") begin
            seg = NUMERAL_SEGS[code - "0"];
         end else if (code == PERIOD) begin
            seg = POINT_BIT;
         end else begin
            foreach (SYMBOL_CODES[k]) if (code == SYMBOL_CODES[k]) seg = SYMBOL_SEGS[k];
         end
         return seg;
      endfunction

      function void take_character(logic [7:0] code, logic last);
         int cap;
         int offset;
         digit_word_type w;
         cap = digits_used;
         if (cap < 1) cap = 1;
         if (cap > DIGITS) cap = DIGITS;
         if (code == PERIOD && !period_as_digit && filled > 0) begin
            stored[filled - 1] = stored[filled - 1] | POINT_BIT;
         end else if (filled < cap) begin
            stored[filled] = segment_pattern(code);
            filled++;
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            offset = right_justify ? DIGITS - filled : 0;
            for (int p = 0; p < DIGITS; p++) begin
               w.position = 2'(p);
               w.segments = (p >= offset && p - offset < filled) ? stored[p - offset] : BLANK;
               w.overflow = dropped;
               w.last_digit = (p == DIGITS - 1);
               expected_words.push_back(w);
            end
            clear_frame();
         end
      endfunction

      task log_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_digit_word(digit_word_type got);
         digit_word_type want;
         if (expected_words.size() == 0) begin
            log_mismatch($sformatf("unexpected digit word, position %0d segments %h",
                                   got.position, got.segments));
            return;
         end
         want = expected_words.pop_front();
         if (got.position != want.position)
            log_mismatch($sformatf("digit_index %0d, expected %0d", got.position, want.position));
         if (got.segments != want.segments)
            log_mismatch($sformatf("segments %h, expected %h at position %0d",
                                   got.segments, want.segments, want.position));
         if (got.overflow != want.overflow)
            log_mismatch($sformatf("overflow %0b, expected %0b at position %0d",
                                   got.overflow, want.overflow, want.position));
         if (got.last_digit != want.last_digit)
            log_mismatch($sformatf("last_digit %0b, expected %0b at position %0d",
                                   got.last_digit, want.last_digit, want.position));
      endtask

      function int words_pending();
         return expected_words.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_character;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_digit_index;
   logic [7:0] rsp_segments;
   logic       rsp_overflow;
   logic       rsp_last_digit;
   logic       csr_wen;
   logic [1:0] csr_index;
   logic [2:0] csr_wdata;

   bit gaps_on = 1'b1;
   bit stall_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;

   digit_word_board_type board = new();

   text_to_seven_segment_display u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_index (rsp_digit_index),
      .rsp_segments    (rsp_segments),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_digit  (rsp_last_digit),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic send_character(logic [7:0] code, logic last);
      while (gaps_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_character <= code;
      req_end_of_text <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_character(code, last);
   endtask

   task automatic send_text(string text, bit close);
      for (int i = 0; i < text.len(); i++) send_character(text[i], close && i == text.len() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.words_pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(bit justify, bit period_alone, logic [2:0] used);
      logic [1:0] index [3];
      logic [2:0] value [3];
      index = '{tsd_pkg::CSR_RIGHT_JUSTIFY, tsd_pkg::CSR_PERIOD_AS_DIGIT,
                tsd_pkg::CSR_DIGITS_USED};
      value = '{{2'b00, justify}, {2'b00, period_alone}, used};
      for (int k = 0; k < 3; k++) begin
         csr_wen <= 1'b1;
         csr_index <= index[k];
         csr_wdata <= value[k];
         @(posedge clock);
         board.set_register(index[k], value[k]);
      end
      csr_wen <= 1'b0;
   endtask

   function automatic logic [7:0] random_character();
      int pick;
      pick = $urandom_range(99);
      if (pick < 22) return PERIOD;
      if (pick < 34) return 8'("A") + 8'($urandom_range(25));
      if (pick < 46) return 8'("a") + 8'($urandom_range(25));
      if (pick < 58) return 8'("0") + 8'($urandom_range(9));
      if (pick < 70) return SYMBOL_CODES[$urandom_range(4)];
      return 8'($urandom_range(255));
   endfunction

   initial begin
      digit_word_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.position = rsp_digit_index;
            got.segments = rsp_segments;
            got.overflow = rsp_overflow;
            got.last_digit = rsp_last_digit;
            board.check_digit_word(got);
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(stall_on && $urandom_range(99) < 10);
         end
      end
   end

   initial begin
      #3000000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int frame_len;
      int sent;
      logic [2:0] used;
      reset = 1'b1;
      req_valid = 1'b0;
      req_character = 8'h00;
      req_end_of_text = 1'b0;
      rsp_ready = 1'b0;
      csr_wen = 1'b0;
      csr_index = 2'd0;
      csr_wdata = 3'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(1'b0, 1'b0, 3'd4);
      send_text(".A..", 1'b1);
      send_text("Zz09", 1'b0);
      send_character(8'hFF, 1'b0);
      send_character(PERIOD, 1'b1);
      send_character(8'h00, 1'b0);
      send_text("-_=", 1'b1);
      send_character(QUOTE, 1'b0);
      send_text(" ", 1'b0);
      send_character(8'h80, 1'b1);
      send_text("ab", 1'b0);
      settle();
      configure(1'b0, 1'b0, 3'd1);
      send_text("c", 1'b1);
      settle();
      configure(1'b1, 1'b1, 3'd3);
      send_text("1.23", 1'b1);
      settle();
      configure(1'b1, 1'b0, 3'd0);
      send_text("7.", 1'b1);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         gaps_on = (phase != 3);
         stall_on = (phase != 3);
         case (phase)
            0: used = 3'd0;
            1: used = 3'd7;
            2: used = 3'd4;
            4: used = 3'd1;
            default: used = 3'($urandom_range(7));
         endcase
         configure(phase[0], phase[1], used);
         if (phase == 6) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_CHARACTERS) begin
            frame_len = $urandom_range(6, 1);
            for (int k = 0; k < frame_len; k++) send_character(random_character(), k == frame_len - 1);
            sent += frame_len;
         end
         settle();
      end

      if (board.mismatches == 0 && board.words_pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== text_to_seven_segment_display.f =====
rtl/tsd_pkg.sv
rtl/tsd_front.sv
rtl/tsd_queue.sv
rtl/tsd_back.sv
rtl/text_to_seven_segment_display.sv
tb/testbench.sv
